>>> hw/rtl/planar_glyph_blitter_top_assert.svh
// Assertion macros for the planar glyph blitter.
// Taken in by planar_glyph_blitter_top; expects a clock clk and reset rst in scope.
`ifndef PLANAR_GLYPH_BLITTER_TOP_ASSERT_SVH
`define PLANAR_GLYPH_BLITTER_TOP_ASSERT_SVH

// Condition holds in the same cycle as its trigger.
`define PGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgb: same-cycle check failed");

// Condition holds in the cycle after its trigger.
`define PGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgb: next-cycle check failed");

`endif

>>> hw/rtl/pgb_pkg.sv
// Shared types and fixed constants of the planar glyph blitter.
// No dependencies; imported by planar_glyph_blitter_top.
`default_nettype none

package pgb_pkg;

  // fixed field widths
  localparam int POS_X_W  = 9;
  localparam int POS_Y_W  = 8;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int INDEX_W  = 11;
  localparam int BYTE_W   = 8;
  localparam int GADDR_W  = 12;
  localparam int WORD_W   = 16;
  localparam int SHIFT_W  = 4;
  localparam int COL_W    = POS_X_W - SHIFT_W + 1;  // room for col + 1
  localparam int LINE_W   = POS_Y_W + 1;            // y plus up to 16 rows
  localparam int PLANES   = 4;

  // cell geometry
  localparam logic [WORD_W-1:0]  REGION_LEFT  = 16'hFC00;
  localparam logic [WORD_W-1:0]  REGION_RIGHT = 16'h00FC;
  localparam logic [SHIFT_W-1:0] SHIFT_SPLIT  = 4'd10;
  localparam logic [4:0]         RIGHT_BASE   = 5'd24;

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  // per-beat control that travels down the pipe
  typedef struct packed {
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [SHIFT_W-1:0] shift;
    logic               pass;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;
    logic               tr;
    logic               last;
  } beat_meta_t;

endpackage

`default_nettype wire

>>> hw/rtl/planar_glyph_blitter_top.sv
// Planar glyph blitter: glyph store, row sequencer and three-stage write pipeline.
// Depends on pgb_pkg and planar_glyph_blitter_top_assert.svh.
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  item    | in        | item_valid/item_stall  | req_type, pos_x .. table_byte
//  wr      | out       | wr_valid/wr_stall      | group_address, planeN_bits, mask, last
//
//  A load writes table_byte as it is taken, if table_index fits the store. A draw
//  emits one write per beat, up to 2*GLYPH_ROWS, and the row sequencer issues one beat
//  a cycle while stage 1 is ready. Pipe stages: store read, shift/address, colour.
//  Reset clears the sequencer and pipe valid bits; the glyph store is not cleared.
//  wr_stall freezes the output stage and any full stage ahead; empty ones fill, and a
//  new item is taken in the cycle the previous draw issues its final beat.

module planar_glyph_blitter_top #(
  parameter int GLYPH_ROWS        = 8,
  parameter int LINE_WORDS        = 80,
  parameter int SCREEN_LINES      = 200,
  parameter int GLYPH_STORE_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        req_type,
  input  wire logic [8:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  ink_color,
  input  wire logic [3:0]  paper_color,
  input  wire logic        transparent,
  input  wire logic [10:0] table_index,
  input  wire logic [7:0]  table_byte,
  // write channel
  output logic             wr_valid,
  input  wire logic        wr_stall,
  output logic [11:0]      group_address,
  output logic [15:0]      plane0_bits,
  output logic [15:0]      plane1_bits,
  output logic [15:0]      plane2_bits,
  output logic [15:0]      plane3_bits,
  output logic [15:0]      write_mask,
  output logic             last
);

  import pgb_pkg::*;

  localparam int GROUPS = LINE_WORDS / 4;
  localparam int AW     = $clog2(GLYPH_STORE_BYTES);
  localparam int RW     = $clog2(GLYPH_ROWS + 1);
  localparam int LCW    = $clog2(SCREEN_LINES + 1) + 1;

  // start address of each character, already wrapped into the store
  logic [AW-1:0] base_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_base_tab
    assign base_tab[i] = AW'((i * GLYPH_ROWS) % GLYPH_STORE_BYTES);
  end

  // ---------------------------------------------------------------- accept
  logic accept;
  logic mem_we;
  logic [AW-1:0] ld_addr;

  // sequencer state
  logic               seq_busy;
  logic               seq_pass;
  logic               seq_p1;
  logic [RW-1:0]      seq_row;
  logic [RW-1:0]      seq_rows;
  logic [AW-1:0]      seq_addr;
  logic [AW-1:0]      seq_base;
  logic [POS_Y_W-1:0] seq_y;
  logic [COL_W-1:0]   seq_col;
  logic [SHIFT_W-1:0] seq_shift;
  logic [COLOR_W-1:0] seq_ink;
  logic [COLOR_W-1:0] seq_paper;
  logic               seq_tr;
  logic               seq_final;
  logic               row_end;
  logic               issue;

  // pipe
  logic               s1_valid;
  beat_meta_t         s1_meta;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s2_valid;
  beat_meta_t         s2_meta;
  logic [WORD_W-1:0]  s2_region;
  logic [WORD_W-1:0]  s2_pix;
  logic [GADDR_W-1:0] s2_addr;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !wr_valid || !wr_stall;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign row_end   = (seq_row == seq_rows - RW'(1));
  assign seq_final = row_end && (seq_pass || !seq_p1);
  assign issue     = seq_busy && s1_ready;

  assign item_stall = seq_busy && !(issue && seq_final);
  assign accept     = item_valid && !item_stall;

  assign ld_addr = AW'(table_index);
  assign mem_we  = accept && (req_type == REQ_LOAD) &&
                   (32'(table_index) < GLYPH_STORE_BYTES);

  // draw set-up: visible rows and passes
  logic [COL_W-1:0]   in_col;
  logic [SHIFT_W-1:0] in_shift;
  logic               in_p0_ok, in_p1_ok;
  logic [LCW-1:0]     lines_left;
  logic [RW-1:0]      in_rows;

  always_comb begin
    in_shift   = pos_x[SHIFT_W-1:0];
    in_col     = COL_W'(pos_x[POS_X_W-1:SHIFT_W]);
    in_p0_ok   = (32'(in_col) < GROUPS);
    in_p1_ok   = (in_shift > SHIFT_SPLIT) && (32'(in_col) + 1 < GROUPS);
    lines_left = '0;
    in_rows    = '0;
    if (32'(pos_y) < SCREEN_LINES) begin
      lines_left = LCW'(SCREEN_LINES) - LCW'(pos_y);
      in_rows    = (32'(lines_left) < GLYPH_ROWS) ? RW'(lines_left) : RW'(GLYPH_ROWS);
    end
  end

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy <= 1'b0;
    end else if (accept && (req_type == REQ_DRAW)) begin
      seq_busy <= (in_rows != '0) && (in_p0_ok || in_p1_ok);
    end else if (issue && seq_final) begin
      seq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == REQ_DRAW)) begin
      seq_pass  <= !in_p0_ok;
      seq_p1    <= in_p1_ok;
      seq_row   <= '0;
      seq_rows  <= in_rows;
      seq_addr  <= base_tab[char_code];
      seq_base  <= base_tab[char_code];
      seq_y     <= pos_y;
      seq_col   <= in_col;
      seq_shift <= in_shift;
      seq_ink   <= ink_color;
      seq_paper <= paper_color;
      seq_tr    <= transparent;
    end else if (issue && !seq_final) begin
      if (row_end) begin
        // left run done, restart rows for the next group
        seq_pass <= 1'b1;
        seq_row  <= '0;
        seq_addr <= seq_base;
      end else begin
        seq_row  <= seq_row + RW'(1);
        seq_addr <= (32'(seq_addr) == GLYPH_STORE_BYTES - 1) ? '0 : seq_addr + AW'(1);
      end
    end
  end

  // ---------------------------------------------- stage 1: glyph store read
  logic [BYTE_W-1:0] glyph_store [GLYPH_STORE_BYTES];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_store[ld_addr] <= table_byte;
    end
    if (issue) begin
      s1_byte <= glyph_store[seq_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta.line  <= LINE_W'(seq_y) + LINE_W'(seq_row);
      s1_meta.col   <= seq_col + COL_W'(seq_pass);
      s1_meta.shift <= seq_shift;
      s1_meta.pass  <= seq_pass;
      s1_meta.ink   <= seq_ink;
      s1_meta.paper <= seq_paper;
      s1_meta.tr    <= seq_tr;
      s1_meta.last  <= seq_final;
    end
  end

  // ------------------------------------------- stage 2: shift and address
  logic [WORD_W-1:0] region_n, pix_n;
  logic [4:0]        right_amt;

  always_comb begin
    right_amt = RIGHT_BASE - 5'(s1_meta.shift);
    if (!s1_meta.pass) begin
      region_n = REGION_LEFT >> s1_meta.shift;
      pix_n    = ({s1_byte, 8'h00} >> s1_meta.shift) & region_n;
    end else begin
      region_n = WORD_W'(32'(REGION_RIGHT) << right_amt);
      pix_n    = WORD_W'(32'(s1_byte) << right_amt) & region_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_meta   <= s1_meta;
      s2_region <= region_n;
      s2_pix    <= pix_n;
      s2_addr   <= GADDR_W'(32'(s1_meta.line) * GROUPS + 32'(s1_meta.col));
    end
  end

  // ------------------------------------------ stage 3: colour and output
  logic [WORD_W-1:0] neg_n, mask_n;
  logic [WORD_W-1:0] plane_n [PLANES];

  always_comb begin
    neg_n  = s2_meta.tr ? '0 : (s2_region & ~s2_pix);
    mask_n = s2_meta.tr ? s2_pix : s2_region;
    for (int p = 0; p < PLANES; p++) begin
      plane_n[p] = (s2_pix & {WORD_W{s2_meta.ink[p]}}) |
                   (neg_n & {WORD_W{s2_meta.paper[p]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (s3_ready) begin
      wr_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      group_address <= s2_addr;
      plane0_bits   <= plane_n[0];
      plane1_bits   <= plane_n[1];
      plane2_bits   <= plane_n[2];
      plane3_bits   <= plane_n[3];
      write_mask    <= mask_n;
      last          <= s2_meta.last;
    end
  end

  // ------------------------------------------------------------ checks
  `include "planar_glyph_blitter_top_assert.svh"

  `PGB_ASSERT_NOW(a_take_only_at_end, seq_busy && !item_stall, issue && seq_final)
  `PGB_ASSERT_NEXT(a_final_marks_last, issue && seq_final, s1_valid && s1_meta.last)
  `PGB_ASSERT_NOW(a_row_in_range, seq_busy, seq_row < seq_rows)
  `PGB_ASSERT_NOW(a_bits_inside_mask, wr_valid,
    ((plane0_bits | plane1_bits | plane2_bits | plane3_bits) & ~write_mask) == 16'h0000)

endmodule

`default_nettype wire
